/* src/cdd_pkg.sv */
// Package for the card-detect debouncer: event kinds, debounce-state codes,
// the state record and the register limits. No dependencies.
`default_nettype none

package cdd_pkg;

    localparam int unsigned KIND_W     = 2;
    localparam int unsigned PENDING_W  = 2;
    localparam int unsigned DEBOUNCE_W = 9;

    // Register range and reset value, in millisecond ticks.
    localparam logic [15:0]           DEBOUNCE_MAX   = 16'd300;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MIN   = 9'd1;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 9'd50;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 2'd0,
        KIND_CHANGE  = 2'd1,
        KIND_SUSPEND = 2'd2,
        KIND_RESUME  = 2'd3
    } kind_t;

    typedef enum logic [PENDING_W-1:0] {
        PEND_NONE   = 2'd0,
        PEND_INSERT = 2'd1,
        PEND_REMOVE = 2'd2
    } pending_t;

    typedef struct packed {
        logic                  card_powered;
        logic                  insert_waiting;
        logic                  remove_waiting;
        logic [DEBOUNCE_W-1:0] countdown;
        logic                  suspended;
    } cdd_state_t;

endpackage

`default_nettype wire

/* src/cdd_ifs.sv */
// Handshake interfaces of the card-detect debouncer: event items, status
// items and the debounce register write channel. Depends on cdd_pkg.
`default_nettype none

interface cdd_req_if;
    logic                       valid;
    logic                       ready;
    logic [cdd_pkg::KIND_W-1:0] kind;
    logic                       card_present;

    modport source (output valid, output kind, output card_present, input ready);
    modport sink (input valid, input kind, input card_present, output ready);
endinterface

interface cdd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          power_enable;
    logic [cdd_pkg::PENDING_W-1:0] pending;
    logic                          asleep;

    modport source (output valid, output power_enable, output pending, output asleep,
                    input ready);
    modport sink (input valid, input power_enable, input pending, input asleep,
                  output ready);
endinterface

interface cdd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cdd_pkg::DEBOUNCE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/cdd_step.sv */
// Next-state logic of the card-detect debouncer for one event item.
// Purely combinational. Depends on cdd_pkg.
`default_nettype none

module cdd_step (
    input  wire cdd_pkg::cdd_state_t                cur_state,
    input  wire logic [cdd_pkg::KIND_W-1:0]         kind,
    input  wire logic                               card_present,
    input  wire logic [cdd_pkg::DEBOUNCE_W-1:0]     debounce_ms,
    output cdd_pkg::cdd_state_t                     nxt_state
);
    import cdd_pkg::*;

    logic [DEBOUNCE_W-1:0] count_dec;

    assign count_dec = (cur_state.countdown != '0) ? cur_state.countdown - 1'b1
                                                   : cur_state.countdown;

    always_comb
    begin
        nxt_state = cur_state;
        case (kind_t'(kind))
            KIND_TICK:
            begin
                if (!cur_state.suspended &&
                    (cur_state.insert_waiting || cur_state.remove_waiting))
                begin
                    if (count_dec != '0)
                    begin
                        nxt_state.countdown = count_dec;
                    end
                    else
                    begin
                        // Expiry: act only if the level still agrees.
                        if (cur_state.insert_waiting)
                        begin
                            if (card_present)
                                nxt_state.card_powered = 1'b1;
                        end
                        else if (!card_present)
                        begin
                            nxt_state.card_powered = 1'b0;
                        end
                        nxt_state.insert_waiting = 1'b0;
                        nxt_state.remove_waiting = 1'b0;
                        nxt_state.countdown      = '0;
                    end
                end
            end
            KIND_CHANGE:
            begin
                if (!cur_state.suspended)
                begin
                    if (card_present)
                    begin
                        if (nxt_state.remove_waiting)
                        begin
                            nxt_state.remove_waiting = 1'b0;
                            nxt_state.countdown      = '0;
                        end
                        if (!nxt_state.card_powered && !nxt_state.insert_waiting)
                        begin
                            nxt_state.countdown      = debounce_ms;
                            nxt_state.insert_waiting = 1'b1;
                        end
                    end
                    else
                    begin
                        if (nxt_state.insert_waiting)
                        begin
                            nxt_state.insert_waiting = 1'b0;
                            nxt_state.countdown      = '0;
                        end
                        if (nxt_state.card_powered && !nxt_state.remove_waiting)
                        begin
                            nxt_state.countdown      = debounce_ms;
                            nxt_state.remove_waiting = 1'b1;
                        end
                    end
                end
            end
            KIND_SUSPEND:
            begin
                nxt_state.insert_waiting = 1'b0;
                nxt_state.remove_waiting = 1'b0;
                nxt_state.countdown      = '0;
                nxt_state.card_powered   = 1'b0;
                nxt_state.suspended      = 1'b1;
            end
            KIND_RESUME:
            begin
                if (cur_state.suspended)
                begin
                    nxt_state.suspended      = 1'b0;
                    nxt_state.insert_waiting = 1'b0;
                    nxt_state.remove_waiting = 1'b0;
                    nxt_state.countdown      = '0;
                    nxt_state.card_powered   = card_present;
                end
            end
            default:
            begin
                nxt_state = cur_state;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/card_detect_debounce_power_top.sv */
// Top level of the card-detect debouncer with card power control.
// Depends on cdd_pkg, cdd_ifs (interfaces) and cdd_step.
//
// Usage:
//   req carries event items: kind (tick of one millisecond, detect change,
//   suspend, resume) and the sampled card_present level. rsp returns one
//   status item per event: power_enable, pending and asleep as they stand
//   after that event. cfg writes the debounce time in ticks; values outside
//   1 to 300 are dropped. Write it only while no item is in flight.
//   Path: an item accepted on req is captured in the input register, then
//   updates the state register and is offered on rsp from that register.
//   Throughput: one item per cycle while rsp is taken; the state update is
//   one level of flag and 9-bit countdown logic between the input register
//   and the state register, which doubles as the result register.
//   Reset: power off, no debounce pending, awake, debounce time 50 ticks.
//   Stall: while rsp is not taken the update stage holds; req stays ready
//   until the input register is also occupied.
`default_nettype none

module card_detect_debounce_power_top (
    input  wire logic clk,
    input  wire logic rst_n,
    cdd_req_if.sink   req,
    cdd_rsp_if.source rsp,
    cdd_cfg_if.sink   cfg
);
    import cdd_pkg::*;

    logic                  in_valid_reg;
    logic [KIND_W-1:0]     in_kind_reg;
    logic                  in_present_reg;
    logic                  out_valid_reg;
    cdd_state_t            st_reg;
    cdd_state_t            st_next;
    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic                  advance;
    logic                  cfg_in_range;

    // The update stage moves when it holds an item and the result slot frees up.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    assign cfg_in_range = (cfg.data >= DEBOUNCE_MIN) &&
                          ({7'd0, cfg.data} <= DEBOUNCE_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            debounce_reg <= DEBOUNCE_RESET;
        else if (cfg.valid && cfg_in_range)
            debounce_reg <= cfg.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_kind_reg    <= req.kind;
            in_present_reg <= req.card_present;
        end
    end

    cdd_step u_step (
        .cur_state    (st_reg),
        .kind         (in_kind_reg),
        .card_present (in_present_reg),
        .debounce_ms  (debounce_reg),
        .nxt_state    (st_next)
    );

    // The state only changes when a new result is loaded, so the state
    // register also serves as the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                st_reg <= st_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.power_enable = st_reg.card_powered;
    assign rsp.pending      = st_reg.insert_waiting ? PEND_INSERT :
                              (st_reg.remove_waiting ? PEND_REMOVE : PEND_NONE);
    assign rsp.asleep       = st_reg.suspended;

    a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !(st_reg.insert_waiting && st_reg.remove_waiting))
        else $error("insert and remove debounce pending together");

    a_asleep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.suspended |-> (!st_reg.card_powered && !st_reg.insert_waiting &&
                              !st_reg.remove_waiting))
        else $error("suspended with power or debounce active");

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.insert_waiting || st_reg.remove_waiting) |-> (st_reg.countdown != '0))
        else $error("debounce pending with countdown at zero");

    a_debounce_range: assert property (@(posedge clk) disable iff (!rst_n)
        (debounce_reg >= DEBOUNCE_MIN) && ({7'd0, debounce_reg} <= DEBOUNCE_MAX))
        else $error("debounce time out of range");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> $stable(st_reg))
        else $error("state changed while result stalled");

endmodule

`default_nettype wire
